// ===== rtl/assert_macros.svh =====
// Assertion helpers for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define CCQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define CCQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ccq_pkg.sv =====
package ccq_pkg;

    localparam int QueueDepthDefault = 256;
    localparam int CodeW    = 8;
    localparam int ArgW     = 16;
    localparam int PayloadW = 64;
    localparam int EntryW   = CodeW + 2 * ArgW + PayloadW;

    localparam logic [CodeW-1:0] SetInEqReset    = 8'd1;
    localparam logic [CodeW-1:0] SetOutEqReset   = 8'd2;
    localparam logic [CodeW-1:0] ResetInEqReset  = 8'd3;
    localparam logic [CodeW-1:0] ResetOutEqReset = 8'd4;

    // Register addresses (word index)
    localparam logic [1:0] RegSetInEq    = 2'd0;
    localparam logic [1:0] RegSetOutEq   = 2'd1;
    localparam logic [1:0] RegResetInEq  = 2'd2;
    localparam logic [1:0] RegResetOutEq = 2'd3;

    localparam logic OpPush = 1'b0;
    localparam logic OpPop  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN_EV,
        S_APPEND,
        S_POP_RD,
        S_POP_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear_live;   // wipe one live bit at the scan pointer
        logic load_cmd;     // capture the input beat
        logic scan_start;   // zero the scan offset
        logic scan_next;    // advance the scan offset
        logic mem_read;     // read slot at head + offset
        logic evaluate;     // act on read data
        logic append;       // write the command at the tail
        logic pop_start;    // begin head skipping
        logic pop_read;     // read slot at head
        logic pop_eval;     // retire or deliver head slot
        logic out_load;     // present the result
    } t_ctrl;

    typedef struct packed {
        logic scan_end;     // offset reached occupancy
        logic pop_empty;    // occupancy is zero
        logic pop_hit;      // head slot is live
        logic clear_end;    // clearing pass finished
    } t_stat;

endpackage

// ===== rtl/ccq_ctrl.sv =====
module ccq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_opcode,
    input  logic           i_out_busy,
    input  ccq_pkg::t_stat i_stat,
    output logic           o_ready,
    output ccq_pkg::t_ctrl o_ctrl
);
    import ccq_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctrl.clear_live = 1'b1;
                o_ctrl.scan_next  = 1'b1;
                if (i_stat.clear_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.load_cmd = 1'b1;
                    if (i_opcode == OpPush) begin
                        o_ctrl.scan_start = 1'b1;
                        n_state = S_SCAN_RD;
                    end else begin
                        o_ctrl.pop_start = 1'b1;
                        n_state = S_POP_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                // Visit every occupied slot so that a reset cancels all it supersedes
                if (i_stat.scan_end) begin
                    n_state = S_APPEND;
                end else begin
                    o_ctrl.mem_read = 1'b1;
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                o_ctrl.evaluate  = 1'b1;
                o_ctrl.scan_next = 1'b1;
                n_state = S_SCAN_RD;
            end
            S_APPEND: begin
                o_ctrl.append = 1'b1;
                n_state = S_DONE;
            end
            S_POP_RD: begin
                if (i_stat.pop_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_ctrl.pop_read = 1'b1;
                    n_state = S_POP_EV;
                end
            end
            S_POP_EV: begin
                o_ctrl.pop_eval = 1'b1;
                n_state = i_stat.pop_hit ? S_DONE : S_POP_RD;
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_ctrl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/ccq_datapath.sv =====
module ccq_datapath #(
    parameter int QUEUE_DEPTH = ccq_pkg::QueueDepthDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ccq_pkg::t_ctrl            i_ctrl,
    input  logic                      i_opcode,
    input  logic [ccq_pkg::CodeW-1:0] i_cmd_code,
    input  logic [ccq_pkg::ArgW-1:0]  i_first_arg,
    input  logic [ccq_pkg::ArgW-1:0]  i_second_arg,
    input  logic [ccq_pkg::PayloadW-1:0] i_payload,
    input  logic [1:0]                i_key_depth,
    input  logic                      i_is_barrier,
    input  logic [ccq_pkg::CodeW-1:0] i_set_in,
    input  logic [ccq_pkg::CodeW-1:0] i_set_out,
    input  logic [ccq_pkg::CodeW-1:0] i_rst_in,
    input  logic [ccq_pkg::CodeW-1:0] i_rst_out,
    output ccq_pkg::t_stat            o_stat,
    output logic                      o_accepted,
    output logic                      o_merged,
    output logic                      o_out_valid,
    output logic [ccq_pkg::CodeW-1:0] o_out_cmd_code,
    output logic [ccq_pkg::ArgW-1:0]  o_out_first_arg,
    output logic [ccq_pkg::ArgW-1:0]  o_out_second_arg,
    output logic [ccq_pkg::PayloadW-1:0] o_out_payload,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_fill_level
);
    import ccq_pkg::*;

    localparam int IdxW = $clog2(QUEUE_DEPTH);
    localparam int OccW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OccW-1:0] DepthVal = OccW'(QUEUE_DEPTH);

    // Slot storage: one memory for the entry, flops for live bits
    logic [EntryW-1:0] r_mem [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_live;
    logic [EntryW-1:0] r_rd;

    logic [IdxW-1:0] r_head;
    logic [OccW-1:0] r_occ;
    logic [OccW-1:0] r_off;
    logic            r_merged, r_accepted, r_valid;
    logic            r_opcode, r_barrier;
    logic [1:0]      r_depth;
    logic [CodeW-1:0] r_code;
    logic [ArgW-1:0] r_a1, r_a2;
    logic [PayloadW-1:0] r_pl;
    logic [EntryW-1:0] r_res;

    logic [IdxW-1:0] w_scan_idx, w_tail_idx, w_rd_idx, w_wr_idx;
    logic [IdxW:0]   w_sum;
    logic [IdxW:0]   w_tsum;
    logic            w_per_out, w_per_in, w_cancel, w_match, w_we;
    logic [CodeW-1:0] e_code;
    logic [ArgW-1:0] e_a1, e_a2;
    logic [EntryW-1:0] w_entry;

    assign w_entry = {r_code, r_a1, r_a2, r_pl};
    assign {e_code, e_a1, e_a2} = r_rd[EntryW-1 -: CodeW + 2*ArgW];

    // Wrap head + offset and head + occupancy into the ring
    always_comb begin
        w_sum = {1'b0, r_head} + (IdxW+1)'(r_off);
        if (w_sum >= (IdxW+1)'(QUEUE_DEPTH)) begin
            w_sum = w_sum - (IdxW+1)'(QUEUE_DEPTH);
        end
        w_tsum = {1'b0, r_head} + (IdxW+1)'(r_occ);
        if (w_tsum >= (IdxW+1)'(QUEUE_DEPTH)) begin
            w_tsum = w_tsum - (IdxW+1)'(QUEUE_DEPTH);
        end
    end
    assign w_scan_idx = w_sum[IdxW-1:0];
    assign w_tail_idx = w_tsum[IdxW-1:0];
    assign w_rd_idx   = i_ctrl.pop_read ? r_head : w_scan_idx;

    // Judge the slot just read; only the first matching live slot merges
    always_comb begin
        w_per_out = (r_code == i_rst_out);
        w_per_in  = !w_per_out && (r_code == i_rst_in);
        w_cancel  = (w_per_out && e_code == i_set_out && e_a1 == r_a1 && e_a2 >= r_a2)
                 || (w_per_in && e_code == i_set_in && e_a1 >= r_a1);
        w_match   = !r_merged && !r_barrier && (e_code == r_code)
                 && (r_depth < 2'd2 || e_a1 == r_a1)
                 && (r_depth != 2'd3 || e_a2 == r_a2);
    end

    assign w_we = (i_ctrl.evaluate && r_live[w_scan_idx] && !w_cancel && w_match)
               || (i_ctrl.append && !r_merged && r_occ != DepthVal);
    assign w_wr_idx = i_ctrl.append ? w_tail_idx : w_scan_idx;

    // Memory port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_idx] <= w_entry;
        end
        if (i_ctrl.mem_read || i_ctrl.pop_read) begin
            r_rd <= r_mem[w_rd_idx];
        end
    end

    // Control state of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= '0;
            r_head     <= '0;
            r_occ      <= '0;
            r_off      <= '0;
            r_merged   <= 1'b0;
            r_accepted <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_ctrl.scan_start) begin
                r_off    <= '0;
                r_merged <= 1'b0;
            end
            if (i_ctrl.scan_next) begin
                r_off <= r_off + 1'b1;
            end
            if (i_ctrl.clear_live) begin
                r_live[r_off[IdxW-1:0]] <= 1'b0;
            end
            if (i_ctrl.evaluate && r_live[w_scan_idx]) begin
                if (w_cancel) begin
                    r_live[w_scan_idx] <= 1'b0;
                end else if (w_match) begin
                    r_merged <= 1'b1;
                end
            end
            if (i_ctrl.append) begin
                r_accepted <= r_merged || (r_occ != DepthVal);
                if (!r_merged && r_occ != DepthVal) begin
                    r_live[w_tail_idx] <= 1'b1;
                    r_occ <= r_occ + 1'b1;
                end
            end
            if (i_ctrl.pop_start) begin
                r_valid <= 1'b0;
                r_accepted <= 1'b0;
                r_merged <= 1'b0;
            end
            if (i_ctrl.pop_eval) begin
                r_live[r_head] <= 1'b0;
                r_head <= (r_head == IdxW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_occ  <= r_occ - 1'b1;
                if (r_live[r_head]) begin
                    r_valid <= 1'b1;
                    r_res   <= r_rd;
                end
            end
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_cmd) begin
            r_opcode  <= i_opcode;
            r_code    <= i_cmd_code;
            r_a1      <= i_first_arg;
            r_a2      <= i_second_arg;
            r_pl      <= i_payload;
            r_depth   <= i_key_depth;
            r_barrier <= i_is_barrier;
        end
    end

    assign o_stat.scan_end  = (r_off == r_occ);
    assign o_stat.pop_empty = (r_occ == '0);
    assign o_stat.pop_hit   = r_live[r_head];
    assign o_stat.clear_end = (r_off == OccW'(QUEUE_DEPTH - 1));

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            o_accepted   <= (r_opcode == OpPush) && r_accepted;
            o_merged     <= (r_opcode == OpPush) && r_merged;
            o_out_valid  <= (r_opcode == OpPop) && r_valid;
            o_fill_level <= r_occ;
            if (r_opcode == OpPop && r_valid) begin
                {o_out_cmd_code, o_out_first_arg, o_out_second_arg, o_out_payload} <= r_res;
            end else begin
                {o_out_cmd_code, o_out_first_arg, o_out_second_arg, o_out_payload} <= '0;
            end
        end
    end

endmodule

// ===== rtl/coalescing_command_queue.sv =====
// Coalescing command queue.
// Input channel (i_valid/o_ready) carries push or pop beats; the output
// channel (o_valid/i_ready) carries one result beat per input beat.
// Configuration: APB-style port, four 8-bit code registers at 0x0..0xC.
// A push scans every occupied slot once, reading then evaluating each,
// cancelling superseded EQ sets and merging on a key match, then appends
// at the tail unless it merged or the queue is full.
// A pop reads head slots, discarding cancelled ones, until it delivers a
// live slot or finds the queue empty. The slot memory is shared by these
// steps; one beat is worked on at a time.
// After reset the live bits are cleared in one pass over all slots, during
// which o_ready is low; configuration writes are taken throughout.
// Results sit in an output register; a stalled receiver holds the result,
// while the next beat may already be accepted and worked on, waiting only
// for the output register to drain before it is written.
module coalescing_command_queue #(
    parameter int QUEUE_DEPTH = ccq_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [ccq_pkg::CodeW-1:0] i_cmd_code,
    input  logic [ccq_pkg::ArgW-1:0]  i_first_arg,
    input  logic [ccq_pkg::ArgW-1:0]  i_second_arg,
    input  logic [ccq_pkg::PayloadW-1:0] i_payload,
    input  logic [1:0]  i_key_depth,
    input  logic        i_is_barrier,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_accepted,
    output logic        o_merged,
    output logic        o_out_valid,
    output logic [ccq_pkg::CodeW-1:0] o_out_cmd_code,
    output logic [ccq_pkg::ArgW-1:0]  o_out_first_arg,
    output logic [ccq_pkg::ArgW-1:0]  o_out_second_arg,
    output logic [ccq_pkg::PayloadW-1:0] o_out_payload,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_fill_level,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ccq_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  r_out_valid;
    logic [CodeW-1:0] r_set_in, r_set_out, r_rst_in, r_rst_out;

    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_in  <= SetInEqReset;
            r_set_out <= SetOutEqReset;
            r_rst_in  <= ResetInEqReset;
            r_rst_out <= ResetOutEqReset;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                RegSetInEq:    r_set_in  <= pwdata[CodeW-1:0];
                RegSetOutEq:   r_set_out <= pwdata[CodeW-1:0];
                RegResetInEq:  r_rst_in  <= pwdata[CodeW-1:0];
                RegResetOutEq: r_rst_out <= pwdata[CodeW-1:0];
                default: ;
            endcase
        end
    end

    // Register read
    always_comb begin
        case (paddr[3:2])
            RegSetInEq:    prdata = {24'd0, r_set_in};
            RegSetOutEq:   prdata = {24'd0, r_set_out};
            RegResetInEq:  prdata = {24'd0, r_rst_in};
            RegResetOutEq: prdata = {24'd0, r_rst_out};
            default:       prdata = '0;
        endcase
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    assign o_valid = r_out_valid;

    ccq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_opcode   (i_opcode),
        .i_out_busy (r_out_valid && !i_ready),
        .i_stat     (w_stat),
        .o_ready    (o_ready),
        .o_ctrl     (w_ctrl)
    );

    ccq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (w_ctrl),
        .i_opcode         (i_opcode),
        .i_cmd_code       (i_cmd_code),
        .i_first_arg      (i_first_arg),
        .i_second_arg     (i_second_arg),
        .i_payload        (i_payload),
        .i_key_depth      (i_key_depth),
        .i_is_barrier     (i_is_barrier),
        .i_set_in         (r_set_in),
        .i_set_out        (r_set_out),
        .i_rst_in         (r_rst_in),
        .i_rst_out        (r_rst_out),
        .o_stat           (w_stat),
        .o_accepted       (o_accepted),
        .o_merged         (o_merged),
        .o_out_valid      (o_out_valid),
        .o_out_cmd_code   (o_out_cmd_code),
        .o_out_first_arg  (o_out_first_arg),
        .o_out_second_arg (o_out_second_arg),
        .o_out_payload    (o_out_payload),
        .o_fill_level     (o_fill_level)
    );

endmodule

// ===== rtl/ccq_checker.sv =====
`include "assert_macros.svh"

module ccq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_accepted,
    input logic       o_merged,
    input logic       o_out_valid,
    input logic [8:0] o_fill_level
);
    // A merge always counts as taken
    `CCQ_ASSERT_IMP(a_merge_acc, i_clk, i_rst_n, o_valid && o_merged, o_accepted, "merge not accepted")
    // A result never reports both a push and a pop outcome
    `CCQ_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid && o_out_valid, !o_accepted && !o_merged, "mixed result")
    // Stalled result holds
    `CCQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_fill_level), "result dropped")
    // Input is not taken in the cycle after one was accepted
    `CCQ_ASSERT_NXT(a_one, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second beat taken early")
endmodule

bind coalescing_command_queue ccq_checker u_ccq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_accepted   (o_accepted),
    .o_merged     (o_merged),
    .o_out_valid  (o_out_valid),
    .o_fill_level (o_fill_level)
);
